// File: rtl/ccpr_pkg.sv
// ----------------------------------------------------------------------------
// ccpr_pkg
// Shared types, constants and the glyph font of the character cell renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpr_pkg;

  // Fixed field widths.
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 32;

  // Cell geometry. CELL_PIXELS and GLYPH_SCALE are powers of two.
  localparam int unsigned CELL_PIXELS  = 64;
  localparam int unsigned CELL_BITS    = 6;
  localparam int unsigned GLYPH_SCALE  = 4;
  localparam int unsigned GLYPH_CELLS  = 5;
  localparam int unsigned GLYPH_SPAN   = GLYPH_CELLS * GLYPH_SCALE;
  localparam int unsigned GLYPH_OFFSET = (CELL_PIXELS - GLYPH_SPAN) / 2;

  // Character codes used by the case fold.
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_CASE_GAP = 8'h20;

  // Colors.
  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_PALE = 8'd120;
  localparam logic [COLOR_W-1:0] COLOR_NONE = 8'd0;

  // Configuration register indexes.
  localparam logic CFG_ROWS_IDX = 1'b0;
  localparam logic CFG_COLS_IDX = 1'b1;
  localparam logic [CFG_W-1:0] CFG_GRID_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_MARK_SEG   = 2'd1,
    OP_RENDER_PIX = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_RENDER
  } state_e;

  typedef struct packed {
    logic clear_en;
    logic write_char;
    logic start_mark;
    logic mark_en;
    logic read_pixel;
    logic load_out;
  } ccpr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mark_done;
  } ccpr_status_t;

  // Font of the 26 letters. Byte k is glyph column k, bit j of it is glyph row j.
  function automatic logic [39:0] glyph_font(input logic [4:0] idx);
    logic [39:0] font;
    case (idx)
      5'd0:    font = 40'h00_1F_05_05_1F;
      5'd1:    font = 40'h00_0A_15_15_1F;
      5'd2:    font = 40'h00_11_11_11_0E;
      5'd3:    font = 40'h00_0E_11_11_1F;
      5'd4:    font = 40'h00_11_15_15_1F;
      5'd5:    font = 40'h00_01_05_05_1F;
      5'd6:    font = 40'h00_1D_15_11_0E;
      5'd7:    font = 40'h00_1F_04_04_1F;
      5'd8:    font = 40'h00_00_11_1F_11;
      5'd9:    font = 40'h00_0F_10_10_08;
      5'd10:   font = 40'h00_11_0A_04_1F;
      5'd11:   font = 40'h00_10_10_10_1F;
      5'd12:   font = 40'h1F_02_04_02_1F;
      5'd13:   font = 40'h00_1F_04_02_1F;
      5'd14:   font = 40'h00_0E_11_11_0E;
      5'd15:   font = 40'h00_02_05_05_1F;
      5'd16:   font = 40'h00_1E_19_11_0E;
      5'd17:   font = 40'h00_12_0D_05_1F;
      5'd18:   font = 40'h00_09_15_15_12;
      5'd19:   font = 40'h00_00_01_1F_01;
      5'd20:   font = 40'h00_0F_10_10_0F;
      5'd21:   font = 40'h07_08_10_08_07;
      5'd22:   font = 40'h1F_08_04_08_1F;
      5'd23:   font = 40'h11_0A_04_0A_11;
      5'd24:   font = 40'h01_02_1C_02_01;
      5'd25:   font = 40'h00_00_13_15_19;
      default: font = 40'h0;
    endcase
    return font;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ccpr_ctrl.sv
// ----------------------------------------------------------------------------
// ccpr_ctrl
// Sequencer of the renderer: clearing pass, item dispatch, segment walk and
// the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpr_ctrl
  import ccpr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [IN_USER_W-1:0] in_op_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire ccpr_status_t         status_i,
  output ccpr_cmd_t                 cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  op_e    op;

  assign op     = op_e'(in_op_i);
  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (op)
            OP_WRITE_CHAR: cmd_o.write_char = 1'b1;
            OP_MARK_SEG: begin
              cmd_o.start_mark = 1'b1;
              state_d          = ST_MARK;
            end
            OP_RENDER_PIX: begin
              cmd_o.read_pixel = 1'b1;
              state_d          = ST_RENDER;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MARK: begin
        cmd_o.mark_en = 1'b1;
        if (status_i.mark_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RENDER: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/ccpr_datapath.sv
// ----------------------------------------------------------------------------
// ccpr_datapath
// Character and highlight stores, segment walker, glyph lookup and the
// output pixel register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpr_datapath
  import ccpr_pkg::*;
#(
  parameter int unsigned GRID_ROWS_MAX = 64,
  parameter int unsigned GRID_COLS_MAX = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  output logic      [OUT_DATA_W-1:0] out_data_o,
  input  wire ccpr_cmd_t             cmd_i,
  output ccpr_status_t               status_o
);

  localparam int unsigned CELL_COUNT = GRID_ROWS_MAX * GRID_COLS_MAX;
  localparam int unsigned ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned LIM_W      = 9;
  localparam logic [LIM_W-1:0]  ROW_LIM   = LIM_W'(GRID_ROWS_MAX);
  localparam logic [LIM_W-1:0]  COL_LIM   = LIM_W'(GRID_COLS_MAX);
  localparam logic [ADDR_W-1:0] ADDR_COLS = ADDR_W'(GRID_COLS_MAX);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [CELL_W-1:0] OFF       = CELL_W'(GLYPH_OFFSET);
  localparam logic [CELL_W-1:0] SPAN      = CELL_W'(GLYPH_SPAN);
  localparam int unsigned       GRID_IDX_W = PIX_W - CELL_BITS;

  // Input fields.
  logic [CELL_W-1:0] in_row, in_col, in_end_row, in_end_col;
  logic [CHAR_W-1:0] in_char;
  logic [PIX_W-1:0]  in_px, in_py;

  assign in_row     = in_data_i[5:0];
  assign in_col     = in_data_i[11:6];
  assign in_char    = in_data_i[19:12];
  assign in_end_row = in_data_i[25:20];
  assign in_end_col = in_data_i[31:26];
  assign in_px      = in_data_i[43:32];
  assign in_py      = in_data_i[55:44];

  // Configuration registers.
  logic [CFG_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_GRID_RESET;
      cols_q <= CFG_GRID_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ROWS_IDX) begin
        rows_q <= cfg_wdata_i;
      end else begin
        cols_q <= cfg_wdata_i;
      end
    end
  end

  // Clearing sweep counter.
  logic [ADDR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  assign status_o.clear_last = (clr_q == ADDR_LAST);

  // Segment walker.
  logic [CELL_W-1:0] mr_q, mc_q, er_q, ec_q;
  logic [CELL_W-1:0] mr_step, mc_step;
  logic              mark_in_grid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_mark) begin
      mr_q <= in_row;
      mc_q <= in_col;
      er_q <= in_end_row;
      ec_q <= in_end_col;
    end else if (cmd_i.mark_en) begin
      mr_q <= mr_step;
      mc_q <= mc_step;
    end
  end

  always_comb begin
    mr_step = mr_q;
    mc_step = mc_q;
    if (mr_q < er_q) begin
      mr_step = mr_q + CELL_W'(1);
    end else if (mr_q > er_q) begin
      mr_step = mr_q - CELL_W'(1);
    end
    if (mc_q < ec_q) begin
      mc_step = mc_q + CELL_W'(1);
    end else if (mc_q > ec_q) begin
      mc_step = mc_q - CELL_W'(1);
    end
  end

  assign status_o.mark_done = (mr_q == er_q) && (mc_q == ec_q);
  assign mark_in_grid = ({3'b000, mr_q} < ROW_LIM) && ({3'b000, mc_q} < COL_LIM);

  // Address generation.
  logic [ADDR_W-1:0] wr_addr, mark_addr, rd_addr;
  logic              wr_in_grid;
  logic [GRID_IDX_W-1:0] pix_row, pix_col;

  assign pix_row    = in_py[PIX_W-1:CELL_BITS];
  assign pix_col    = in_px[PIX_W-1:CELL_BITS];
  assign wr_addr    = ADDR_W'(in_row) * ADDR_COLS + ADDR_W'(in_col);
  assign mark_addr  = ADDR_W'(mr_q) * ADDR_COLS + ADDR_W'(mc_q);
  assign rd_addr    = ADDR_W'(pix_row) * ADDR_COLS + ADDR_W'(pix_col);
  assign wr_in_grid = ({3'b000, in_row} < ROW_LIM) && ({3'b000, in_col} < COL_LIM);

  // Stores.
  logic [CHAR_W-1:0] char_mem [CELL_COUNT];
  logic              hl_mem   [CELL_COUNT];
  logic [CHAR_W-1:0] char_rd_q;
  logic              hl_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      char_mem[clr_q] <= '0;
    end else if (cmd_i.write_char && wr_in_grid) begin
      char_mem[wr_addr] <= in_char;
    end
    if (cmd_i.read_pixel) begin
      char_rd_q <= char_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      hl_mem[clr_q] <= 1'b0;
    end else if (cmd_i.mark_en && mark_in_grid) begin
      hl_mem[mark_addr] <= 1'b1;
    end
    if (cmd_i.read_pixel) begin
      hl_rd_q <= hl_mem[rd_addr];
    end
  end

  // Pixel position inside its cell, and the area test.
  logic [LIM_W-1:0]  nr, nc;
  logic              area_hit;
  logic [CELL_W-1:0] lx_q, ly_q;
  logic              inside_q;

  always_comb begin
    nr = ({2'b00, rows_q} > ROW_LIM) ? ROW_LIM : {2'b00, rows_q};
    nc = ({2'b00, cols_q} > COL_LIM) ? COL_LIM : {2'b00, cols_q};
    area_hit = ({3'b000, pix_col} < nc) && ({3'b000, pix_row} < nr);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_pixel) begin
      lx_q     <= in_px[CELL_BITS-1:0];
      ly_q     <= in_py[CELL_BITS-1:0];
      inside_q <= area_hit;
    end
  end

  // Glyph lookup on the registered cell contents.
  logic [CHAR_W-1:0] ucode, letter_ofs;
  logic              is_letter, in_box, glyph_on, black;
  logic [CELL_W-1:0] gx, gy;
  logic [2:0]        gcol, grow;
  logic [39:0]       font;
  logic [7:0]        font_col;

  always_comb begin
    ucode = char_rd_q;
    if (char_rd_q >= CHAR_LOWER_A && char_rd_q <= CHAR_LOWER_Z) begin
      ucode = char_rd_q - CHAR_CASE_GAP;
    end
    is_letter  = (ucode >= CHAR_UPPER_A) && (ucode <= CHAR_UPPER_Z);
    letter_ofs = ucode - CHAR_UPPER_A;
    gx         = lx_q - OFF;
    gy         = ly_q - OFF;
    in_box     = (lx_q >= OFF) && (ly_q >= OFF) && (gx < SPAN) && (gy < SPAN);
    gcol       = 3'(gx / GLYPH_SCALE);
    grow       = 3'(gy / GLYPH_SCALE);
    font       = glyph_font(letter_ofs[4:0]);
    font_col   = font[{gcol, 3'b000} +: 8];
    glyph_on   = is_letter && in_box && font_col[grow];
    black      = (lx_q == '0) || (ly_q == '0) || glyph_on;
  end

  // Output pixel register.
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic               in_area_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      in_area_q <= inside_q;
      if (inside_q && !black) begin
        red_q   <= COLOR_FULL;
        green_q <= COLOR_FULL;
        blue_q  <= hl_rd_q ? COLOR_PALE : COLOR_FULL;
      end else begin
        red_q   <= COLOR_NONE;
        green_q <= COLOR_NONE;
        blue_q  <= COLOR_NONE;
      end
    end
  end

  assign out_data_o = {7'b0000000, in_area_q, blue_q, green_q, red_q};

endmodule

`default_nettype wire

// File: rtl/char_cell_pixel_renderer_unit.sv
// ----------------------------------------------------------------------------
// char_cell_pixel_renderer_unit
// Text-mode character generator: a character grid with a highlight map,
// rendered one pixel per render beat with borders, glyphs and highlight color.
// ----------------------------------------------------------------------------
// Render: the store read is registered when a render beat is accepted, and
// the pixel is composed and registered into the output register once that
// register is empty or being taken; tvalid rises with it.
// Items: tready is high only in the idle state, so a write, render or
// segment mark is finished before the next beat is taken.
// Reset: config registers return to 64; the stores are then swept to zero at
// one cell per cycle over all GRID_ROWS_MAX*GRID_COLS_MAX cells (4096 by
// default), during which no input beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module char_cell_pixel_renderer_unit
  import ccpr_pkg::*;
#(
  parameter int unsigned GRID_ROWS_MAX = 64,
  parameter int unsigned GRID_COLS_MAX = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port: index 0 is rows_in_use, index 1 is cols_in_use.
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  // Input stream.
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata from bit 0: cell_row[5:0], cell_col[11:6], char_code[19:12],
  // end_row[25:20], end_col[31:26], pixel_x[43:32], pixel_y[55:44].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser from bit 0: op[1:0].
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // Output stream.
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // tdata from bit 0: red[7:0], green[15:8], blue[23:16], in_area[24],
  // zeros above.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  // The controller sees only the handshakes, the op code and the datapath status;
  // every payload bit stays in the datapath.
  ccpr_cmd_t    cmd;
  ccpr_status_t status;

  ccpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds both stores, the configuration registers, the
  // segment walker and the output pixel register.
  ccpr_datapath #(
    .GRID_ROWS_MAX (GRID_ROWS_MAX),
    .GRID_COLS_MAX (GRID_COLS_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire
